/* sv/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and byte-level functions for the encryption core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int BlockW = 128;
  localparam int HalfW  = 64;

  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW  = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic   valid;
    block_t state;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte j of a block sits at bits 127-8j down to 120-8j.
  function automatic logic [7:0] get_byte(input block_t b, input int j);
    return b[BlockW-1-8*j -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage

/* sv/aes128_block_encrypt_core.sv */
// ----------------------------------------------------------------------------
// AES-128 ECB encryption core
// Fully unrolled round pipeline, one block per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  input   | in_valid, in_stall, in_plain_*      | request in
//  output  | out_valid, out_stall, out_cipher_*  | request out
//  config  | cfg_we, cfg_index, cfg_wdata        | key write
//
// The accepting edge loads the initial AddRoundKey register; each round adds
// one register and the output register one more, so a request passes the
// AddRoundKey register, the round registers and the output register in turn
// before out_valid rises and the result can be taken.
// A new request is accepted every cycle while the output is not stalled; the
// unrolled round stages set the throughput of one block per cycle.
// The whole pipeline holds when out_stall is high while out_valid is set; in_stall mirrors it.
// Reset clears the valid bits and the key to zero. A request accepted in the
// cycle after a key write already uses the new key: the round keys follow the
// key register one round per cycle, in step with the request.
module aes128_block_encrypt_core import aes_pkg::*; #(
  parameter int ROUND_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HalfW-1:0]  in_plain_high,
  input  logic [HalfW-1:0]  in_plain_low,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HalfW-1:0]  out_cipher_high,
  output logic [HalfW-1:0]  out_cipher_low,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [HalfW-1:0]  cfg_wdata
);

  block_t round_keys [ROUND_COUNT+1];
  stage_t stages [ROUND_COUNT+1];
  stage_t out_r;
  logic   adv;

  // The pipeline moves as one; a stalled output holds every stage.
  assign adv      = !out_stall || !out_r.valid;
  assign in_stall = !adv;

  aes_key_sched #(.ROUND_COUNT(ROUND_COUNT)) u_key (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .round_keys
  );

  // Initial AddRoundKey stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stages[0].valid <= 1'b0;
    end else if (adv) begin
      stages[0].valid <= in_valid;
    end
    if (adv) begin
      stages[0].state <= {in_plain_high, in_plain_low} ^ round_keys[0];
    end
  end

  for (genvar r = 1; r <= ROUND_COUNT; r++) begin : g_round
    aes_round #(.MIX(r != ROUND_COUNT)) u_round (
      .clk, .rst_n, .adv,
      .stage_in(stages[r-1]), .round_key(round_keys[r]), .stage_out(stages[r])
    );
  end

  // Output register parts the pipeline from the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r.valid <= stages[ROUND_COUNT].valid;
    end
    if (adv) begin
      out_r.state <= stages[ROUND_COUNT].state;
    end
  end

  assign out_valid       = out_r.valid;
  assign out_cipher_high = out_r.state[BlockW-1:HalfW];
  assign out_cipher_low  = out_r.state[HalfW-1:0];

endmodule

/* sv/aes_round.sv */
// ----------------------------------------------------------------------------
// AES round stage
// One registered round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// ----------------------------------------------------------------------------
module aes_round import aes_pkg::*; #(
  parameter bit MIX = 1'b1
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  stage_t stage_in,
  input  block_t round_key,
  output stage_t stage_out
);

  stage_t stage_r, stage_nxt;
  block_t shifted, mixed;

  always_comb begin
    logic [7:0] a [4];
    logic [7:0] d [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[BlockW-1-8*(r+4*c) -: 8] = sbox(get_byte(stage_in.state, r + 4*((c+r)%4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r] = get_byte(shifted, 4*c + r);
        d[r] = xtime(a[r]);
      end
      for (int r = 0; r < 4; r++) begin
        mixed[BlockW-1-8*(4*c+r) -: 8] =
          d[r] ^ d[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
    end
    stage_nxt.valid = stage_in.valid;
    stage_nxt.state = (MIX ? mixed : shifted) ^ round_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      stage_r.valid <= stage_nxt.valid;
    end
    if (adv) begin
      stage_r.state <= stage_nxt.state;
    end
  end

  assign stage_out = stage_r;

endmodule

/* sv/aes_key_sched.sv */
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Holds the key registers and the expanded round keys, rebuilt on each write.
// ----------------------------------------------------------------------------
module aes_key_sched import aes_pkg::*; #(
  parameter int ROUND_COUNT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [HalfW-1:0]  cfg_wdata,
  output block_t            round_keys [ROUND_COUNT+1]
);

  // Round key 0 is the key register itself. Each later round key has its own
  // register, built from the previous round key, so each register sees one
  // SubWord and a few XORs.
  block_t key_r;
  block_t rk_r [1:ROUND_COUNT];

  // Round constant for expansion step i: x to the power i-1 in GF(2^8).
  function automatic logic [7:0] rcon_of(input int i);
    logic [7:0] rc;
    rc = 8'h01;
    for (int k = 1; k < i; k++) begin
      rc = xtime(rc);
    end
    return rc;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_r[BlockW-1:HalfW] <= cfg_wdata;
        CFG_KEY_LOW:  key_r[HalfW-1:0]      <= cfg_wdata;
        default:      key_r <= key_r;
      endcase
    end
  end

  // Round key i is registered from round key i-1, in the cycle after it. After a key write the new
  // schedule therefore moves down the rounds one stage per cycle, in step with
  // the first request accepted under the new key.
  always_ff @(posedge clk) begin
    for (int i = 1; i <= ROUND_COUNT; i++) begin
      logic [31:0] w0, w1, w2, w3, t;
      t  = sub_word({round_keys[i-1][23:0], round_keys[i-1][31:24]})
           ^ {rcon_of(i), 24'h0};
      w0 = round_keys[i-1][127:96] ^ t;
      w1 = round_keys[i-1][95:64] ^ w0;
      w2 = round_keys[i-1][63:32] ^ w1;
      w3 = round_keys[i-1][31:0] ^ w2;
      rk_r[i] <= {w0, w1, w2, w3};
    end
  end

  always_comb begin
    round_keys[0] = key_r;
    for (int i = 1; i <= ROUND_COUNT; i++) begin
      round_keys[i] = rk_r[i];
    end
  end

endmodule

/* sv/aes_checker.sv */
// ----------------------------------------------------------------------------
// AES core port checker
// Watches the ports of the encryption core over time.
// ----------------------------------------------------------------------------
module aes_checker import aes_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [HalfW-1:0] out_cipher_high,
  input logic [HalfW-1:0] out_cipher_low
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cipher_high)
      && $stable(out_cipher_low))
    else $error("stalled result changed");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aes128_block_encrypt_core aes_checker u_aes_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_cipher_high, .out_cipher_low
);
